### src/assert_macros.svh
// Assertion macros used by the packetizer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/uspk_pkg.sv
// Types and constants of the USB serial receive packetizer.
`default_nettype none
package uspk_pkg;

   localparam int FIFO_DEPTH  = 512 - (2 * 8);
   localparam int MAX_PACKET  = 64;
   localparam int QUEUE_DEPTH = 4;

   localparam int ADDR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int NCNT_W   = $clog2(MAX_PACKET - 1);
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int KIND_W   = 3;
   localparam int PLEN_W   = 7;
   localparam int LINES_W  = 4;
   localparam int BYTE_W   = 8;

   localparam logic [KIND_W-1:0] KIND_RX     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BREAK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TOKEN  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PURGE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

   localparam logic [BYTE_W-1:0] HDR_BREAK   = 8'(1 << 4);
   localparam logic [3:0]        HDR_STATUS  = 4'h1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  rx_byte;
      logic [PLEN_W-1:0]  buf_len;
      logic [LINES_W-1:0] modem_lines;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              nak;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              short_tok;
      logic [NCNT_W-1:0] max_n;
   } cmd_type;

endpackage
`default_nettype wire

### src/usb_serial_rx_fifo_packetizer_unit.sv
// Top level of the USB serial receive FIFO and bulk-IN packetizer.
// Request beats enter a 4-entry command queue at up to one per cycle while it is
// not full; kinds 5 to 7 are taken and dropped. The back end retires an rx byte,
// break, purge or reset command straight from idle. An IN token yields a NAK beat,
// a two-beat break packet or a data packet of two header beats and n bytes, one
// beat per cycle while the response side is free, read through the single read
// port of the 496-byte FIFO RAM. A stall on the response side holds the back end
// while the queue keeps taking requests. No clearing pass follows reset.
`default_nettype none
module usb_serial_rx_fifo_packetizer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire uspk_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output uspk_pkg::rsp_type      rsp_data
);
   import uspk_pkg::*;

   logic    queue_full;
   logic    push;
   cmd_type push_data;
   logic    cmd_pop;
   logic    cmd_valid;
   cmd_type cmd_data;

   uspk_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push      (push),
      .push_data (push_data)
   );

   uspk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (queue_full),
      .pop      (cmd_pop),
      .pop_valid(cmd_valid),
      .pop_data (cmd_data)
   );

   uspk_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

### src/uspk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module uspk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/uspk_front.sv
// Front end: accepts request beats and classifies them into commands.
`default_nettype none
module uspk_front (
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire uspk_pkg::req_type req_data,
   input  wire logic             queue_full,
   output logic                  push,
   output uspk_pkg::cmd_type     push_data
);
   import uspk_pkg::*;

   logic [PLEN_W-1:0] plen_clamped;
   logic              known_kind;

   assign req_ready    = !queue_full;
   assign known_kind   = (req_data.kind == KIND_RX) || (req_data.kind == KIND_BREAK) ||
                         (req_data.kind == KIND_TOKEN) || (req_data.kind == KIND_PURGE) ||
                         (req_data.kind == KIND_RESET);
   assign push         = req_valid && req_ready && known_kind;
   assign plen_clamped = (req_data.buf_len > PLEN_W'(MAX_PACKET)) ?
                         PLEN_W'(MAX_PACKET) : req_data.buf_len;

   always_comb begin
      push_data.kind      = req_data.kind;
      push_data.data      = (req_data.kind == KIND_TOKEN) ?
                            {req_data.modem_lines, HDR_STATUS} : req_data.rx_byte;
      push_data.short_tok = (req_data.buf_len <= PLEN_W'(2));
      push_data.max_n     = NCNT_W'(plen_clamped - PLEN_W'(2));
   end
endmodule
`default_nettype wire

### src/uspk_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module uspk_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire uspk_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output uspk_pkg::cmd_type      pop_data
);
   import uspk_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### src/uspk_back.sv
// Back end: owns the byte FIFO and break flag, and emits packet beats.
`default_nettype none
`include "assert_macros.svh"
module uspk_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire uspk_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output uspk_pkg::rsp_type      rsp_data
);
   import uspk_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BRK1 = 2'd1;
   localparam logic [1:0] ST_HDR1 = 2'd2;
   localparam logic [1:0] ST_DATA = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              brk_ff, brk_in;
   logic [NCNT_W-1:0] remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [CNT_W:0]    wr_sum;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_idx_next;
   logic [NCNT_W-1:0] take_n;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   uspk_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(FIFO_DEPTH)
   ) u_fifo_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(cmd_data.data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign wr_sum      = (CNT_W+1)'(rd_idx_ff) + (CNT_W+1)'(fill_ff);
   assign wr_addr     = (wr_sum >= (CNT_W+1)'(FIFO_DEPTH)) ?
                        ADDR_W'(wr_sum - (CNT_W+1)'(FIFO_DEPTH)) : ADDR_W'(wr_sum);
   assign rd_idx_next = (rd_idx_ff == ADDR_W'(FIFO_DEPTH - 1)) ?
                        '0 : rd_idx_ff + ADDR_W'(1);
   assign take_n      = (CNT_W'(cmd_data.max_n) > fill_ff) ?
                        NCNT_W'(fill_ff) : cmd_data.max_n;

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      fill_in      = fill_ff;
      brk_in       = brk_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.kind)
                  KIND_RX: begin
                     cmd_pop = 1'b1;
                     if (fill_ff != CNT_W'(FIFO_DEPTH)) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  KIND_BREAK: begin
                     cmd_pop = 1'b1;
                     brk_in  = 1'b1;
                  end
                  KIND_TOKEN: begin
                     if (out_free) begin
                        cmd_pop      = 1'b1;
                        rsp_valid_in = 1'b1;
                        priority if (cmd_data.short_tok || (!brk_ff && fill_ff == '0)) begin
                           rsp_data_in = '{out_byte: '0, nak: 1'b1, last: 1'b1};
                        end else if (brk_ff) begin
                           brk_in      = 1'b0;
                           rsp_data_in = '{out_byte: cmd_data.data, nak: 1'b0, last: 1'b0};
                           state_in    = ST_BRK1;
                        end else begin
                           rsp_data_in = '{out_byte: cmd_data.data, nak: 1'b0, last: 1'b0};
                           rd_en       = 1'b1;
                           remain_in   = take_n;
                           state_in    = ST_HDR1;
                        end
                     end
                  end
                  KIND_PURGE: begin
                     cmd_pop   = 1'b1;
                     rd_idx_in = '0;
                     fill_in   = '0;
                  end
                  KIND_RESET: begin
                     cmd_pop   = 1'b1;
                     rd_idx_in = '0;
                     fill_in   = '0;
                     brk_in    = 1'b0;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_BRK1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: HDR_BREAK, nak: 1'b0, last: 1'b1};
               state_in     = ST_IDLE;
            end
         end
         ST_HDR1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: '0, nak: 1'b0, last: 1'b0};
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: rd_data, nak: 1'b0,
                                last: (remain_ff == NCNT_W'(1))};
               rd_idx_in    = rd_idx_next;
               fill_in      = fill_ff - CNT_W'(1);
               remain_in    = remain_ff - NCNT_W'(1);
               rd_en        = 1'b1;
               rd_addr      = rd_idx_next;
               if (remain_ff == NCNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         fill_ff      <= '0;
         brk_ff       <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         fill_ff      <= fill_in;
         brk_ff       <= brk_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(FIFO_DEPTH), "fill overflow")
   `ASSERT_ALWAYS(a_rd_idx_bound, clock, reset, rd_idx_ff < ADDR_W'(FIFO_DEPTH), "index range")
   `ASSERT_IMPLIES(a_data_remain, clock, reset, state_ff == ST_DATA,
      (remain_ff != '0) && (CNT_W'(remain_ff) <= fill_ff), "data count mismatch")
   `ASSERT_IMPLIES(a_nak_last, clock, reset, rsp_valid_ff && rsp_data_ff.nak,
      rsp_data_ff.last, "nak beat not last")
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the USB serial receive FIFO and bulk-IN packetizer.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import uspk_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_BEATS    = 70;
   localparam int FILL_BEATS     = 70;
   localparam int N_DIRECTED     = 27;

   localparam rsp_type NAK_BEAT = '{8'h00, 1'b1, 1'b1};
   localparam rsp_type NO_BEAT  = '0;

   typedef struct packed {
      req_type     req;
      logic [1:0]  n_typed;
      rsp_type     first;
      rsp_type     second;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_row_type req_shadow = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic [BYTE_W-1:0] rx_ring [FIFO_DEPTH];
   int                ring_head = 0;
   int                ring_fill = 0;
   bit                break_flag = 1'b0;

   rsp_type fresh_beats [$];
   rsp_type beats_due [$];
   rsp_type want;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{'{KIND_TOKEN,    8'h00, 7'd0,   4'h0}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd64,  4'hF}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_TOKEN,    8'hFF, 7'd127, 4'h0}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_BREAK,    8'h00, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd2,   4'hF}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd3,   4'hF}, 2'd2,
        '{{4'hF, HDR_STATUS}, 1'b0, 1'b0}, '{HDR_BREAK, 1'b0, 1'b1}},
      '{'{KIND_TOKEN,    8'h00, 7'd3,   4'h0}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_RX,       8'h00, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_RX,       8'hFF, 7'd127, 4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_RX,       8'h5A, 7'd1,   4'h3}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_UNUSED_5, 8'hFF, 7'd127, 4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_UNUSED_6, 8'hFF, 7'd3,   4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_UNUSED_7, 8'h00, 7'd64,  4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd3,   4'hA}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd127, 4'h5}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd64,  4'h0}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_RX,       8'hA5, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_BREAK,    8'hFF, 7'd127, 4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_RX,       8'h3C, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd127, 4'h0}, 2'd2,
        '{{4'h0, HDR_STATUS}, 1'b0, 1'b0}, '{HDR_BREAK, 1'b0, 1'b1}},
      '{'{KIND_TOKEN,    8'h00, 7'd64,  4'h3}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_RX,       8'h11, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_PURGE,    8'hFF, 7'd127, 4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd10,  4'h6}, 2'd1, NAK_BEAT, NO_BEAT},
      '{'{KIND_BREAK,    8'h00, 7'd0,   4'h0}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_RESET,    8'hFF, 7'd127, 4'hF}, 2'd0, NO_BEAT,  NO_BEAT},
      '{'{KIND_TOKEN,    8'h00, 7'd10,  4'h9}, 2'd1, NAK_BEAT, NO_BEAT}
   };

   usb_serial_rx_fifo_packetizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rsp_type pkt_beat(logic [BYTE_W-1:0] b, logic nk, logic lst);
      pkt_beat = '{b, nk, lst};
   endfunction

   task automatic advance_packetizer(input req_type r);
      int                len;
      int                n;
      logic [BYTE_W-1:0] hdr0;
      hdr0 = {r.modem_lines, HDR_STATUS};
      unique case (r.kind)
         KIND_RX: begin
            if (ring_fill < FIFO_DEPTH) begin
               rx_ring[(ring_head + ring_fill) % FIFO_DEPTH] = r.rx_byte;
               ring_fill++;
            end
         end
         KIND_BREAK: break_flag = 1'b1;
         KIND_TOKEN: begin
            len = int'(r.buf_len);
            if (len <= 2) begin
               fresh_beats.push_back(NAK_BEAT);
            end else if (break_flag) begin
               break_flag = 1'b0;
               fresh_beats.push_back(pkt_beat(hdr0, 1'b0, 1'b0));
               fresh_beats.push_back(pkt_beat(HDR_BREAK, 1'b0, 1'b1));
            end else if (ring_fill == 0) begin
               fresh_beats.push_back(NAK_BEAT);
            end else begin
               if (len > MAX_PACKET) len = MAX_PACKET;
               n = len - 2;
               if (n > ring_fill) n = ring_fill;
               fresh_beats.push_back(pkt_beat(hdr0, 1'b0, 1'b0));
               fresh_beats.push_back(pkt_beat(8'h00, 1'b0, 1'b0));
               for (int i = 0; i < n; i++) begin
                  fresh_beats.push_back(pkt_beat(rx_ring[ring_head], 1'b0, i == n - 1));
                  ring_head = (ring_head + 1) % FIFO_DEPTH;
               end
               ring_fill -= n;
            end
         end
         KIND_PURGE: begin
            ring_head = 0;
            ring_fill = 0;
         end
         KIND_RESET: begin
            ring_head = 0;
            ring_fill = 0;
            break_flag = 1'b0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            fresh_beats.delete();
            advance_packetizer(req_data);
            if (req_shadow.n_typed == 2'd0) begin
               foreach (fresh_beats[i]) beats_due.push_back(fresh_beats[i]);
            end else begin
               beats_due.push_back(req_shadow.first);
               if (req_shadow.n_typed == 2'd2) beats_due.push_back(req_shadow.second);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = beats_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h got %h",
                           $time, want.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.nak !== want.nak) begin
                  $display("%0t: nak expected %b got %b", $time, want.nak, rsp_data.nak);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %b got %b", $time, want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: watchdog expired, %0d beats outstanding",
                        $time, beats_due.size());
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   task automatic send_beat(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= row.req;
      req_shadow <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_packets();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_due.size() != 0) @(posedge clock);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type     row;
      int unsigned      pick;
      row = '0;
      pick = $urandom_range(99);
      if (pick < 50)      row.req.kind = KIND_RX;
      else if (pick < 80) row.req.kind = KIND_TOKEN;
      else if (pick < 88) row.req.kind = KIND_BREAK;
      else if (pick < 92) row.req.kind = KIND_PURGE;
      else if (pick < 96) row.req.kind = KIND_RESET;
      else if (pick < 97) row.req.kind = KIND_UNUSED_5;
      else if (pick < 98) row.req.kind = KIND_UNUSED_6;
      else                row.req.kind = KIND_UNUSED_7;
      row.req.rx_byte     = BYTE_W'($urandom);
      row.req.modem_lines = LINES_W'($urandom);
      if ($urandom_range(9) == 0) row.req.buf_len = PLEN_W'($urandom_range(127, 65));
      else                        row.req.buf_len = PLEN_W'($urandom_range(64, 0));
      random_row = row;
   endfunction

   initial begin
      stim_row_type row;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_beat(directed_rows[i]);
      drain_packets();

      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         if (phase == 2) begin
            // empty the ring, then load enough bytes for a full-size packet
            row = '0;
            row.req.kind = KIND_PURGE;
            send_beat(row);
            for (int i = 0; i < FILL_BEATS; i++) begin
               row = random_row();
               row.req.kind = KIND_RX;
               send_beat(row);
            end
         end
         for (int i = 0; i < PHASE_BEATS; i++) send_beat(random_row());
         drain_packets();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (beats_due.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, beats_due.size());
      end
      if (mismatch_count == 0 && beats_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
